// ===== rtl/mevq_pkg.sv =====
`timescale 1ns / 1ps
package mevq_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;
    localparam int EV_W   = 3 * BYTE_W;

    // command codes on the input channel
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [BYTE_W-1:0] ST_SYS_BASE   = 8'hF0;
    localparam logic [BYTE_W-1:0] ST_CLOCK      = 8'hF8;
    localparam logic [BYTE_W-1:0] ST_START      = 8'hFA;
    localparam logic [BYTE_W-1:0] ST_CONTINUE   = 8'hFB;
    localparam logic [BYTE_W-1:0] ST_STOP       = 8'hFC;
    localparam logic [BYTE_W-1:0] ST_SYS_RESET  = 8'hFF;

    // data bytes following a status, indexed by the status high nibble 8..F
    localparam logic [1:0] DATA_LEN [8] = '{2'd2, 2'd2, 2'd2, 2'd2,
                                            2'd1, 2'd1, 2'd2, 2'd0};

    // request from the walker to the output stage
    typedef struct packed {
        logic              push;
        logic              fin;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } t_ost_cmd;

    // what the output stage can take this cycle
    typedef struct packed {
        logic can_push;
        logic can_fin;
    } t_ost_sts;

    function automatic logic status_kept(input logic [BYTE_W-1:0] st);
        logic keep;
        keep = st[BYTE_W-1];
        if (st >= ST_SYS_BASE) begin
            keep = (st == ST_CLOCK) || (st == ST_START) || (st == ST_CONTINUE) ||
                   (st == ST_STOP) || (st == ST_SYS_RESET);
        end
        return keep;
    endfunction

    function automatic logic [1:0] data_len(input logic [BYTE_W-1:0] st);
        return DATA_LEN[st[6:4]];
    endfunction

endpackage

// ===== rtl/midi_event_queue_drain_unit.sv =====
`timescale 1ns / 1ps
// MIDI event queue with byte drain.
// Input channel (i_valid / o_stall): a push word (i_command = 0) stores
// status and two data bytes at the write pointer and marks the slot valid,
// overwriting whatever was there. A drain word (i_command = 1) walks valid
// slots from the read pointer and emits the kept events as bytes, up to
// i_byte_budget (saturated at MAX_READ_BYTES).
// Output channel (o_valid / i_stall): one word per emitted byte; the last
// word of a drain carries o_last and o_byte_count. A drain that emits
// nothing gives a single word with o_byte_valid low and o_last high.
// Sequence: a push is written directly from the idle state. A drain visits
// each slot in two states (memory read, then evaluate and write back), then
// emits the bytes of a kept event; it closes with the read that stops the
// walk, its evaluate and the closing word. The single read port of the event
// memory sets this order. The final word is registered from the closing state
// after the evaluate that ends the walk; each other byte, when the next is pushed.
// Reset: after i_rst_n the block sweeps the event memory clearing valid
// flags, one slot per cycle, with o_stall high.
// A stalled receiver holds the output word and, once the one-byte holding
// stage fills, halts the walk; input words are taken only between drains.
module midi_event_queue_drain_unit #(
    parameter int QUEUE_DEPTH    = 1024,
    parameter int MAX_READ_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_command,
    input  logic [7:0] i_status_byte,
    input  logic [7:0] i_first_data,
    input  logic [7:0] i_second_data,
    input  logic [6:0] i_byte_budget,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last,
    output logic [6:0] o_byte_count
);
    import mevq_pkg::*;

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int MEM_W = EV_W + 1;
    localparam logic [AW-1:0]    LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] MAX_BYTES = CNT_W'(MAX_READ_BYTES);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_wp, n_wp;
    logic [AW-1:0]     r_rp, n_rp;
    logic [AW-1:0]     r_clr, n_clr;
    logic [CNT_W-1:0]  r_budget, n_budget;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [EV_W-1:0]   r_ev, n_ev;
    logic [1:0]        r_dl, n_dl;
    logic [1:0]        r_idx, n_idx;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [MEM_W-1:0]  mem_rdata;
    t_ost_cmd          ost_cmd;
    t_ost_sts          ost_sts;

    logic              in_acc;
    logic              slot_ok;
    logic [BYTE_W-1:0] ev_st;
    logic [1:0]        ev_dl;
    logic [CNT_W:0]    need_sum;

    assign o_stall   = (r_state != S_IDLE);
    assign in_acc    = i_valid && !o_stall;
    assign slot_ok   = mem_rdata[MEM_W-1];
    assign ev_st     = mem_rdata[EV_W-1 -: BYTE_W];
    assign ev_dl     = data_len(ev_st);
    assign need_sum  = {1'b0, r_n} + (CNT_W+1)'(ev_dl) + (CNT_W+1)'(1);
    assign mem_re    = (r_state == S_RD);

    mevq_ram #(
        .WIDTH (MEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rp),
        .o_rdata (mem_rdata)
    );

    mevq_ostage u_ostage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ost_cmd),
        .o_sts        (ost_sts),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_byte_count (o_byte_count)
    );

    // sequencer: push, clear sweep and slot walk
    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_clr     = r_clr;
        n_budget  = r_budget;
        n_n       = r_n;
        n_ev      = r_ev;
        n_dl      = r_dl;
        n_idx     = r_idx;
        mem_we    = 1'b0;
        mem_waddr = r_rp;
        mem_wdata = '0;
        ost_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_command == CMD_PUSH) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_wp;
                        mem_wdata = {1'b1, i_status_byte, i_first_data, i_second_data};
                        n_wp      = (r_wp == LAST_SLOT) ? '0 : r_wp + AW'(1);
                    end else begin
                        n_budget = (i_byte_budget > MAX_BYTES) ? MAX_BYTES : i_byte_budget;
                        n_n      = '0;
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!slot_ok) begin
                    n_state = S_FIN;
                end else if (status_kept(ev_st) && need_sum > {1'b0, r_budget}) begin
                    // does not fit: stays queued
                    n_state = S_FIN;
                end else begin
                    mem_we = 1'b1;
                    n_rp   = (r_rp == LAST_SLOT) ? '0 : r_rp + AW'(1);
                    n_ev   = mem_rdata[EV_W-1:0];
                    n_dl   = ev_dl;
                    n_idx  = '0;
                    n_state = status_kept(ev_st) ? S_EMIT : S_RD;
                end
            end
            S_EMIT: begin
                ost_cmd.push = 1'b1;
                unique case (r_idx)
                    2'd0:    ost_cmd.data = r_ev[EV_W-1 -: BYTE_W];
                    2'd1:    ost_cmd.data = r_ev[2*BYTE_W-1 -: BYTE_W];
                    default: ost_cmd.data = r_ev[BYTE_W-1:0];
                endcase
                if (ost_sts.can_push) begin
                    n_n   = r_n + CNT_W'(1);
                    n_idx = r_idx + 2'd1;
                    if (r_idx == r_dl) begin
                        n_state = S_RD;
                    end
                end
            end
            S_FIN: begin
                ost_cmd.fin   = 1'b1;
                ost_cmd.count = r_n;
                if (ost_sts.can_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_wp    <= '0;
            r_rp    <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_clr   <= n_clr;
        end
    end

    // walk payload
    always_ff @(posedge i_clk) begin
        r_budget <= n_budget;
        r_n      <= n_n;
        r_ev     <= n_ev;
        r_dl     <= n_dl;
        r_idx    <= n_idx;
    end

`ifndef SYNTH
    // a byte that is not the last one means the drain is still running
    a_nonlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state != S_IDLE && r_state != S_CLR))
        else $error("non-final byte with no drain in progress");

    // an empty word can only be the single closing word of a drain
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_last && o_byte_count == '0))
        else $error("empty word is not a closing word");

    // a drain never emits past the configured maximum
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_byte_count <= MAX_BYTES))
        else $error("byte count beyond maximum");
`endif

endmodule

// ===== rtl/mevq_ram.sv =====
`timescale 1ns / 1ps
module mevq_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // simple dual port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mevq_ostage.sv =====
`timescale 1ns / 1ps
module mevq_ostage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mevq_pkg::t_ost_cmd    i_cmd,
    output mevq_pkg::t_ost_sts    o_sts,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_byte_valid,
    output logic                  o_last,
    output logic [6:0]            o_byte_count
);
    import mevq_pkg::*;

    // one byte is held back until we know whether it ends the read
    logic              r_h_valid;
    logic [BYTE_W-1:0] r_h_byte;
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_bvalid;
    logic              r_o_last;
    logic [CNT_W-1:0]  r_o_count;
    logic              out_free;
    logic              do_push;
    logic              do_fin;

    assign out_free       = !r_o_valid || !i_stall;
    assign o_sts.can_push = !r_h_valid || out_free;
    assign o_sts.can_fin  = out_free;
    assign do_push        = i_cmd.push && o_sts.can_push;
    assign do_fin         = i_cmd.fin && out_free;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (do_push) begin
                r_h_valid <= 1'b1;
            end else if (do_fin) begin
                r_h_valid <= 1'b0;
            end
            if ((do_push && r_h_valid) || do_fin) begin
                r_o_valid <= 1'b1;
            end else if (out_free) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_h_byte <= i_cmd.data;
        end
        if (do_push && r_h_valid) begin
            r_o_byte   <= r_h_byte;
            r_o_bvalid <= 1'b1;
            r_o_last   <= 1'b0;
            r_o_count  <= '0;
        end else if (do_fin) begin
            r_o_byte   <= r_h_valid ? r_h_byte : '0;
            r_o_bvalid <= r_h_valid;
            r_o_last   <= 1'b1;
            r_o_count  <= r_h_valid ? i_cmd.count : '0;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_byte   = r_o_byte;
    assign o_byte_valid = r_o_bvalid;
    assign o_last       = r_o_last;
    assign o_byte_count = r_o_count;

endmodule
